// ===== rtl/core/csw_rle_pkg.sv =====
`timescale 1ns / 1ps

package csw_rle_pkg;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int RATE_W      = 24;
   localparam int TICK_NS_W   = 16;
   localparam int PULSE_W     = 31;
   localparam int LONG_W      = 32;
   localparam int TOTAL_W     = 64;
   localparam int HALF_W      = TOTAL_W / 2;
   localparam int ESC_W       = 3;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = RATE_W;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_RATE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_NS     = 2'd1;

   localparam logic [RATE_W-1:0]    RATE_RESET    = 24'd44100;
   localparam logic [TICK_NS_W-1:0] TICK_NS_RESET = 16'd1000;

   // conversion arithmetic
   localparam int NS_W       = 30;
   localparam logic [NS_W-1:0] NS_PER_SECOND = 30'd1000000000;
   localparam int PART_W     = HALF_W + NS_W;
   localparam int PROD_W     = TOTAL_W + NS_W;
   localparam int DIVISOR_W  = RATE_W + TICK_NS_W;
   localparam int DIV_STEPS  = PROD_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [TOTAL_W-1:0] PULSE_MAX = {{(TOTAL_W-PULSE_W){1'b0}}, {PULSE_W{1'b1}}};

   // escape sequence positions
   localparam logic [ESC_W-1:0] ESC_IDLE  = 3'd0;
   localparam logic [ESC_W-1:0] ESC_BYTE0 = 3'd1;
   localparam logic [ESC_W-1:0] ESC_BYTE1 = 3'd2;
   localparam logic [ESC_W-1:0] ESC_BYTE2 = 3'd3;
   localparam logic [ESC_W-1:0] ESC_BYTE3 = 3'd4;

endpackage

// ===== rtl/core/csw_rle_divider.sv =====
`timescale 1ns / 1ps

module csw_rle_divider (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [csw_rle_pkg::PROD_W-1:0]         dividend,
   input  logic [csw_rle_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                   done,
   output logic [csw_rle_pkg::TOTAL_W-1:0]        quotient
);
   import csw_rle_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0]     work_ff, work_in;

   logic [DIVISOR_W:0]    r1, r1s, r2, r2s, dwide;
   logic                  ge1, ge2;

   // two restoring steps per cycle
   always_comb begin
      dwide = {1'b0, divisor};
      r1    = {rem_ff, work_ff[PROD_W-1]};
      ge1   = (r1 >= dwide);
      r1s   = ge1 ? (r1 - dwide) : r1;
      r2    = {r1s[DIVISOR_W-1:0], work_ff[PROD_W-2]};
      ge2   = (r2 >= dwide);
      r2s   = ge2 ? (r2 - dwide) : r2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      if (busy_ff) begin
         rem_in  = r2s[DIVISOR_W-1:0];
         work_in = {work_ff[PROD_W-3:0], ge1, ge2};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         rem_in  = '0;
         work_in = dividend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   // quotient above 64 bits saturates
   assign done     = done_ff;
   assign quotient = (|work_ff[PROD_W-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : work_ff[TOTAL_W-1:0];

endmodule

// ===== rtl/core/csw_rle_pulse_decoder_unit.sv =====
`timescale 1ns / 1ps
// path: a pulse byte's item reaches rsp through states ADD, MUL_LO, MUL_HI, SUM, LOAD,
//    DIV and DIFF; DIV is the 2-bit-per-cycle restoring divider (47 steps, 94-bit product)
// flow: escape bytes and the first three length bytes leave req_tready high; a pulse
//    byte or last length byte drops it until its item loads, after any previous item leaves rsp
// reset: synchronous active high; totals and escape state cleared, sample_rate 44100,
//    tick_ns 1000, no item pending on rsp

module csw_rle_pulse_decoder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] data_byte
   input  logic                                  req_tuser,  // [0] block_start
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [31:0]                           rsp_tdata,  // [30:0] pulse_ticks
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [csw_rle_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [csw_rle_pkg::CSR_DATA_W-1:0]    csr_data
);
   import csw_rle_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ADD    = 3'd1;
   localparam logic [2:0] ST_MUL_LO = 3'd2;
   localparam logic [2:0] ST_MUL_HI = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_DIFF   = 3'd6;
   localparam logic [2:0] ST_LOAD   = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [TICK_NS_W-1:0]  tick_ns_ff, tick_ns_in;
   logic [ESC_W-1:0]      esc_ff, esc_in;
   logic [LONG_W-1:0]     long_ff, long_in;
   logic [TOTAL_W-1:0]    sample_total_ff, sample_total_in;
   logic [TOTAL_W-1:0]    tick_total_ff, tick_total_in;
   logic [LONG_W-1:0]     length_ff, length_in;      // pulse length in samples
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [PART_W-1:0]     lo_prod_ff, lo_prod_in;
   logic [PART_W-1:0]     hi_prod_ff, hi_prod_in;
   logic [PROD_W-1:0]     dividend_ff, dividend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                  div_start;
   logic                  div_done;
   logic [TOTAL_W-1:0]    div_quotient;

   logic                  accept;
   logic [TOTAL_W:0]      sum_wide;
   logic [TOTAL_W-1:0]    tick_diff;

   csw_rle_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign div_start  = (state_ff == ST_LOAD);

   // saturating sample accumulation
   assign sum_wide  = {1'b0, sample_total_ff} + {{(TOTAL_W+1-LONG_W){1'b0}}, length_ff};
   assign tick_diff = div_quotient - tick_total_ff;

   // register writes, only while idle
   always_comb begin
      rate_in    = rate_ff;
      tick_ns_in = tick_ns_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SAMPLE_RATE: rate_in    = csr_data;
            REG_TICK_NS:     tick_ns_in = csr_data[TICK_NS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [ESC_W-1:0]   esc;
      logic [LONG_W-1:0]  long_len;
      esc             = esc_ff;
      long_len        = long_ff;
      state_in        = state_ff;
      esc_in          = esc_ff;
      long_in         = long_ff;
      sample_total_in = sample_total_ff;
      tick_total_in   = tick_total_ff;
      length_in       = length_ff;
      divisor_in      = divisor_ff;
      lo_prod_in      = lo_prod_ff;
      hi_prod_in      = hi_prod_ff;
      dividend_in     = dividend_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // block start drops any escape and both totals first
               if (req_tuser) begin
                  esc             = ESC_IDLE;
                  long_len        = '0;
                  sample_total_in = '0;
                  tick_total_in   = '0;
               end
               esc_in  = esc;
               long_in = long_len;
               case (esc)
                  ESC_IDLE: begin
                     if (req_tdata == '0) begin
                        esc_in  = ESC_BYTE0;
                        long_in = '0;
                     end else begin
                        length_in = {{(LONG_W-BYTE_W){1'b0}}, req_tdata};
                        state_in  = ST_ADD;
                     end
                  end
                  ESC_BYTE0: begin
                     long_in = long_len | {24'd0, req_tdata};
                     esc_in  = ESC_BYTE1;
                  end
                  ESC_BYTE1: begin
                     long_in = long_len | {16'd0, req_tdata, 8'd0};
                     esc_in  = ESC_BYTE2;
                  end
                  ESC_BYTE2: begin
                     long_in = long_len | {8'd0, req_tdata, 16'd0};
                     esc_in  = ESC_BYTE3;
                  end
                  ESC_BYTE3: begin
                     // last length byte completes the escaped pulse
                     long_in   = long_len | {req_tdata, 24'd0};
                     length_in = long_len | {req_tdata, 24'd0};
                     esc_in    = ESC_IDLE;
                     state_in  = ST_ADD;
                  end
                  default: begin
                     esc_in = ESC_IDLE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            sample_total_in = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
            divisor_in      = rate_ff * tick_ns_ff;
            state_in        = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            lo_prod_in = sample_total_ff[HALF_W-1:0] * NS_PER_SECOND;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            hi_prod_in = sample_total_ff[TOTAL_W-1:HALF_W] * NS_PER_SECOND;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            // dividend is loaded into the divider the next cycle
            dividend_in = {{(PROD_W-PART_W){1'b0}}, lo_prod_ff}
                        + {hi_prod_ff, {HALF_W{1'b0}}};
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // wait for the previous item to leave the output register
            if (!rsp_valid_ff || rsp_tready) begin
               tick_total_in = div_quotient;
               rsp_valid_in  = 1'b1;
               if (div_quotient <= tick_total_ff) begin
                  rsp_data_in = '0;
               end else if (tick_diff > PULSE_MAX) begin
                  rsp_data_in = PULSE_MAX[PULSE_W-1:0];
               end else begin
                  rsp_data_in = tick_diff[PULSE_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // dividend_ff feeds the divider in the cycle it starts
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rate_ff         <= RATE_RESET;
         tick_ns_ff      <= TICK_NS_RESET;
         esc_ff          <= ESC_IDLE;
         long_ff         <= '0;
         sample_total_ff <= '0;
         tick_total_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rate_ff         <= rate_in;
         tick_ns_ff      <= tick_ns_in;
         esc_ff          <= esc_in;
         long_ff         <= long_in;
         sample_total_ff <= sample_total_in;
         tick_total_ff   <= tick_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      length_ff   <= length_in;
      divisor_ff  <= divisor_in;
      lo_prod_ff  <= lo_prod_in;
      hi_prod_ff  <= hi_prod_in;
      dividend_ff <= dividend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule
